// File: rtl/core/mrs_pkg.sv
// shared types, constants and crc helper for the modbus rtu register slave
`default_nettype none
package mrs_pkg;

  localparam int BUFFER_BYTES_DEF   = 64;
  localparam int REGISTER_COUNT_DEF = 16;
  localparam int CNT_W              = 5;

  localparam logic [1:0] KIND_BYTE = 2'd0;
  localparam logic [1:0] KIND_TICK = 2'd1;
  localparam logic [1:0] KIND_LRD  = 2'd2;
  localparam logic [1:0] KIND_LWR  = 2'd3;

  localparam logic [1:0] CFG_DEV = 2'd0;
  localparam logic [1:0] CFG_RIN = 2'd1;
  localparam logic [1:0] CFG_GAP = 2'd2;

  localparam logic [7:0]  FN_READ   = 8'h03;
  localparam logic [7:0]  FN_WRITE1 = 8'h06;
  localparam logic [7:0]  FN_WRITEN = 8'h10;
  localparam logic [7:0]  FN_EXC    = 8'h80;
  localparam logic [7:0]  EXC_FUNC  = 8'h01;
  localparam logic [7:0]  EXC_ADDR  = 8'h02;
  localparam logic [15:0] CRC_INIT  = 16'hFFFF;
  localparam logic [15:0] CRC_POLY  = 16'hA001;

  localparam logic RES_TX  = 1'b0;
  localparam logic RES_LRD = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_LRD, ST_CHK, ST_DEC, ST_WR, ST_HDR,
    ST_RREQ, ST_RHI, ST_RLO, ST_CRCL, ST_CRCH
  } state_t;

  typedef struct packed {
    logic       wr_en;
    logic [7:0] wr_idx;
    logic [7:0] wr_data;
    logic       rd_en;
    logic [7:0] rd_idx;
  } fb_req_t;

  typedef struct packed {
    logic        wr_en;
    logic [7:0]  wr_idx;
    logic [15:0] wr_data;
    logic        rd_en;
    logic [7:0]  rd_idx;
  } rf_req_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] x;
    x = c ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      x = x[0] ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
    end
    return x;
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/mrs_frame_mem.sv
// receive frame byte buffer, one write and one registered read port
`default_nettype none
module mrs_frame_mem #(
  parameter int BUFFER_BYTES = mrs_pkg::BUFFER_BYTES_DEF
) (
  input  wire logic            clk,
  input  wire mrs_pkg::fb_req_t req,
  output logic [7:0]           rd_data
);
  localparam int BIDX_W = $clog2(BUFFER_BYTES);

  logic [7:0] mem [BUFFER_BYTES];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_idx[BIDX_W-1:0]] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_idx[BIDX_W-1:0]];
    end
  end

  assign rd_data = rd_data_r;
endmodule
`default_nettype wire

// File: rtl/core/mrs_reg_file.sv
// holding register memory with per-entry valid bits, unwritten entries read zero
`default_nettype none
module mrs_reg_file #(
  parameter int REGISTER_COUNT = mrs_pkg::REGISTER_COUNT_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire mrs_pkg::rf_req_t req,
  output logic [15:0]          rd_data
);
  localparam int RIDX_W = (REGISTER_COUNT > 1) ? $clog2(REGISTER_COUNT) : 1;

  logic [15:0]               mem [REGISTER_COUNT];
  logic [REGISTER_COUNT-1:0] vld_r;
  logic [15:0]               rd_data_r;
  logic                      rd_vld_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_idx[RIDX_W-1:0]] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_idx[RIDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (req.wr_en) begin
        vld_r[req.wr_idx[RIDX_W-1:0]] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_vld_r <= vld_r[req.rd_idx[RIDX_W-1:0]];
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_data_r : 16'h0000;
endmodule
`default_nettype wire

// File: rtl/core/modbus_rtu_register_slave.sv
// modbus rtu slave top level: frame collection, evaluation sequencer and reply output
// usage:
//   input channel (in_valid/in_stall) carries one item per handshake: a received
//   byte, an idle time tick, a local register read or a local register write.
//   result channel (out_valid/out_stall) carries reply bytes (result_kind 0, tx_last
//   on the crc high byte) and local read data (result_kind 1).
//   cfg_we/cfg_index/cfg_wdata write device address, registers in use and frame gap.
// sequencing:
//   bytes, writes and non-closing ticks are taken without holding off input; a local
//   read registers the register file read, then waits on any output stall.
//   a closing tick of a frame of four or more bytes scans the frame buffer through
//   its single read port for the crc check, then decodes; a write-multiple then reads
//   two buffer bytes per register and writes it; then each header and crc byte is
//   sent, and per read register a request step and two byte steps, each byte gated
//   by the output register. input is held off (in_stall) during all of this.
// reset: synchronous, rst_n low; registers return to address 1, 16 registers, gap
//   2000; frame buffer empties and holding registers read as zero.
// stall: the output register holds its item until taken; the sequencer waits on it.
`default_nettype none
module modbus_rtu_register_slave #(
  parameter int BUFFER_BYTES   = mrs_pkg::BUFFER_BYTES_DEF,
  parameter int REGISTER_COUNT = mrs_pkg::REGISTER_COUNT_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_kind,
  input  wire logic [7:0]  in_rx_byte,
  input  wire logic [3:0]  in_local_index,
  input  wire logic [15:0] in_local_value,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_result_kind,
  output logic [7:0]       out_tx_byte,
  output logic             out_tx_last,
  output logic [15:0]      out_read_value,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata
);
  localparam int LEN_W = $clog2(BUFFER_BYTES + 1);
  localparam int CNT_W = mrs_pkg::CNT_W;
  localparam logic [7:0] RC8 = 8'(REGISTER_COUNT);

  // configuration
  logic [7:0]  dev_r;
  logic [4:0]  rin_r;
  logic [15:0] gap_r;

  // frame collection
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [15:0]      idle_r, idle_nxt;
  logic [LEN_W-1:0] eval_len_r, eval_len_nxt;
  logic [LEN_W-1:0] sc_r, sc_nxt;

  mrs_pkg::state_t state_r, state_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  crc_lo_r, crc_lo_nxt, crc_hi_r, crc_hi_nxt;
  logic [7:0]  hdr_r [0:6];
  logic [7:0]  hdr_nxt [0:6];
  logic [7:0]  txb_r [0:5];
  logic [7:0]  txb_nxt [0:5];
  logic [2:0]  tx_n_r, tx_n_nxt, tk_r, tk_nxt;
  logic        tx_rd_r, tx_rd_nxt;
  logic [7:0]  start_r, start_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt, wi_r, wi_nxt;
  logic [1:0]  ph_r, ph_nxt;
  logic [7:0]  whi_r, whi_nxt;
  logic        lrd_zero_r, lrd_zero_nxt;

  // output register
  logic        out_valid_r, out_valid_nxt;
  logic        out_kind_r, out_kind_nxt;
  logic [7:0]  out_byte_r, out_byte_nxt;
  logic        out_last_r, out_last_nxt;
  logic [15:0] out_val_r, out_val_nxt;

  mrs_pkg::fb_req_t fb_req;
  mrs_pkg::rf_req_t rf_req;
  logic [7:0]  fb_rdata;
  logic [15:0] rf_rdata;

  mrs_frame_mem #(.BUFFER_BYTES(BUFFER_BYTES)) u_fb (
    .clk(clk), .req(fb_req), .rd_data(fb_rdata)
  );

  mrs_reg_file #(.REGISTER_COUNT(REGISTER_COUNT)) u_rf (
    .clk(clk), .rst_n(rst_n), .req(rf_req), .rd_data(rf_rdata)
  );

  logic             accept, slot_free;
  logic             emit_go, emit_last;
  logic [7:0]       emit_b;
  logic [LEN_W-1:0] pj;
  logic [15:0]      idle_inc, f_start, f_count;
  logic [16:0]      sum17;
  logic [7:0]       lim8, f_fn, lidx8;
  logic             frame_ok;
  logic [8:0]       wbyte;

  assign in_stall  = (state_r != mrs_pkg::ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign slot_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt    = state_r;
    len_nxt      = len_r;
    idle_nxt     = idle_r;
    eval_len_nxt = eval_len_r;
    sc_nxt       = sc_r;
    crc_nxt      = crc_r;
    crc_lo_nxt   = crc_lo_r;
    crc_hi_nxt   = crc_hi_r;
    hdr_nxt      = hdr_r;
    txb_nxt      = txb_r;
    tx_n_nxt     = tx_n_r;
    tk_nxt       = tk_r;
    tx_rd_nxt    = tx_rd_r;
    start_nxt    = start_r;
    cnt_nxt      = cnt_r;
    wi_nxt       = wi_r;
    ph_nxt       = ph_r;
    whi_nxt      = whi_r;
    lrd_zero_nxt = lrd_zero_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_kind_nxt = out_kind_r;
    out_byte_nxt = out_byte_r;
    out_last_nxt = out_last_r;
    out_val_nxt  = out_val_r;
    fb_req       = '0;
    rf_req       = '0;
    emit_go      = 1'b0;
    emit_last    = 1'b0;
    emit_b       = 8'h00;

    idle_inc = (idle_r == 16'hFFFF) ? idle_r : idle_r + 16'd1;
    lidx8    = {4'b0000, in_local_index};
    pj       = sc_r - LEN_W'(1);
    f_fn     = hdr_r[1];
    f_start  = {hdr_r[2], hdr_r[3]};
    f_count  = {hdr_r[4], hdr_r[5]};
    sum17    = {1'b0, f_start} + {1'b0, f_count};
    lim8     = ({3'b000, rin_r} > RC8) ? RC8 : {3'b000, rin_r};
    frame_ok = (hdr_r[0] == dev_r) && (crc_r == {crc_hi_r, crc_lo_r});
    wbyte    = 9'd7 + {3'b000, wi_r, 1'b0} + {7'b0, ph_r};

    case (state_r)
      mrs_pkg::ST_IDLE: begin
        if (accept) begin
          case (in_kind)
            mrs_pkg::KIND_BYTE: begin
              if (len_r < LEN_W'(BUFFER_BYTES)) begin
                fb_req.wr_en   = 1'b1;
                fb_req.wr_idx  = 8'(len_r);
                fb_req.wr_data = in_rx_byte;
                len_nxt        = len_r + LEN_W'(1);
              end
              idle_nxt = 16'h0000;
            end
            mrs_pkg::KIND_TICK: begin
              if (len_r != '0) begin
                if (idle_inc > gap_r) begin
                  // frame closes: latch its length and empty the collector
                  eval_len_nxt = len_r;
                  len_nxt      = '0;
                  idle_nxt     = 16'h0000;
                  sc_nxt       = '0;
                  crc_nxt      = mrs_pkg::CRC_INIT;
                  if (len_r >= LEN_W'(4)) begin
                    state_nxt = mrs_pkg::ST_CHK;
                  end
                end else begin
                  idle_nxt = idle_inc;
                end
              end
            end
            mrs_pkg::KIND_LRD: begin
              rf_req.rd_en  = lidx8 < RC8;
              rf_req.rd_idx = lidx8;
              lrd_zero_nxt  = !(lidx8 < RC8);
              state_nxt     = mrs_pkg::ST_LRD;
            end
            default: begin
              rf_req.wr_en   = lidx8 < RC8;
              rf_req.wr_idx  = lidx8;
              rf_req.wr_data = in_local_value;
            end
          endcase
        end
      end
      mrs_pkg::ST_LRD: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = mrs_pkg::RES_LRD;
          out_byte_nxt  = 8'h00;
          out_last_nxt  = 1'b0;
          out_val_nxt   = lrd_zero_r ? 16'h0000 : rf_rdata;
          state_nxt     = mrs_pkg::ST_IDLE;
        end
      end
      mrs_pkg::ST_CHK: begin
        // stream the buffer: issue read at sc, consume the byte read last cycle
        if (sc_r < eval_len_r) begin
          fb_req.rd_en  = 1'b1;
          fb_req.rd_idx = 8'(sc_r);
        end
        if (sc_r != '0) begin
          if (pj < eval_len_r - LEN_W'(2)) begin
            crc_nxt = mrs_pkg::crc_byte(crc_r, fb_rdata);
          end
          if (pj == eval_len_r - LEN_W'(2)) begin
            crc_lo_nxt = fb_rdata;
          end
          if (pj == eval_len_r - LEN_W'(1)) begin
            crc_hi_nxt = fb_rdata;
          end
          if (pj < LEN_W'(7)) begin
            hdr_nxt[pj[2:0]] = fb_rdata;
          end
        end
        if (sc_r == eval_len_r) begin
          state_nxt = mrs_pkg::ST_DEC;
        end else begin
          sc_nxt = sc_r + LEN_W'(1);
        end
      end
      mrs_pkg::ST_DEC: begin
        crc_nxt   = mrs_pkg::CRC_INIT;
        tk_nxt    = 3'd0;
        tx_rd_nxt = 1'b0;
        tx_n_nxt  = 3'd3;
        start_nxt = f_start[7:0];
        cnt_nxt   = f_count[CNT_W-1:0];
        wi_nxt    = '0;
        ph_nxt    = 2'd0;
        txb_nxt[0] = dev_r;
        txb_nxt[1] = f_fn | mrs_pkg::FN_EXC;
        txb_nxt[2] = mrs_pkg::EXC_ADDR;
        state_nxt  = mrs_pkg::ST_IDLE;
        if (frame_ok) begin
          if (f_fn == mrs_pkg::FN_READ) begin
            if (eval_len_r >= LEN_W'(6)) begin
              state_nxt = mrs_pkg::ST_HDR;
              if (sum17 <= {9'b0, lim8}) begin
                txb_nxt[1] = mrs_pkg::FN_READ;
                txb_nxt[2] = {f_count[6:0], 1'b0};
                tx_rd_nxt  = f_count != 16'h0000;
              end
            end
          end else if (f_fn == mrs_pkg::FN_WRITE1) begin
            if (eval_len_r >= LEN_W'(6)) begin
              state_nxt = mrs_pkg::ST_HDR;
              if (f_start < {8'h00, lim8}) begin
                rf_req.wr_en   = 1'b1;
                rf_req.wr_idx  = f_start[7:0];
                rf_req.wr_data = f_count;
                for (int k = 0; k < 6; k++) begin
                  txb_nxt[k] = hdr_r[k];
                end
                tx_n_nxt = 3'd6;
              end
            end
          end else if (f_fn == mrs_pkg::FN_WRITEN) begin
            if ((eval_len_r >= LEN_W'(7)) &&
                (10'(eval_len_r) >= 10'd7 + {2'b00, hdr_r[6]}) &&
                ({9'b0, hdr_r[6]} >= {f_count, 1'b0})) begin
              if (sum17 > {9'b0, lim8}) begin
                state_nxt = mrs_pkg::ST_HDR;
              end else begin
                txb_nxt[1] = mrs_pkg::FN_WRITEN;
                for (int k = 2; k < 6; k++) begin
                  txb_nxt[k] = hdr_r[k];
                end
                tx_n_nxt  = 3'd6;
                state_nxt = (f_count == 16'h0000) ? mrs_pkg::ST_HDR : mrs_pkg::ST_WR;
              end
            end
          end else begin
            txb_nxt[2] = mrs_pkg::EXC_FUNC;
            state_nxt  = mrs_pkg::ST_HDR;
          end
        end
      end
      mrs_pkg::ST_WR: begin
        // byte pairs from the buffer into consecutive registers
        case (ph_r)
          2'd0: begin
            fb_req.rd_en  = 1'b1;
            fb_req.rd_idx = wbyte[7:0];
            ph_nxt        = 2'd1;
          end
          2'd1: begin
            fb_req.rd_en  = 1'b1;
            fb_req.rd_idx = wbyte[7:0];
            whi_nxt       = fb_rdata;
            ph_nxt        = 2'd2;
          end
          default: begin
            rf_req.wr_en   = 1'b1;
            rf_req.wr_idx  = start_r + {3'b000, wi_r};
            rf_req.wr_data = {whi_r, fb_rdata};
            ph_nxt         = 2'd0;
            wi_nxt         = wi_r + CNT_W'(1);
            if (wi_r + CNT_W'(1) == cnt_r) begin
              state_nxt = mrs_pkg::ST_HDR;
            end
          end
        endcase
      end
      mrs_pkg::ST_HDR: begin
        if (slot_free) begin
          emit_go = 1'b1;
          emit_b  = txb_r[tk_r];
          tk_nxt  = tk_r + 3'd1;
          if (tk_r + 3'd1 == tx_n_r) begin
            state_nxt = tx_rd_r ? mrs_pkg::ST_RREQ : mrs_pkg::ST_CRCL;
          end
        end
      end
      mrs_pkg::ST_RREQ: begin
        rf_req.rd_en  = 1'b1;
        rf_req.rd_idx = start_r + {3'b000, wi_r};
        state_nxt     = mrs_pkg::ST_RHI;
      end
      mrs_pkg::ST_RHI: begin
        if (slot_free) begin
          emit_go   = 1'b1;
          emit_b    = rf_rdata[15:8];
          state_nxt = mrs_pkg::ST_RLO;
        end
      end
      mrs_pkg::ST_RLO: begin
        if (slot_free) begin
          emit_go = 1'b1;
          emit_b  = rf_rdata[7:0];
          wi_nxt  = wi_r + CNT_W'(1);
          state_nxt = (wi_r + CNT_W'(1) == cnt_r) ? mrs_pkg::ST_CRCL : mrs_pkg::ST_RREQ;
        end
      end
      mrs_pkg::ST_CRCL: begin
        if (slot_free) begin
          emit_go   = 1'b1;
          emit_b    = crc_r[7:0];
          state_nxt = mrs_pkg::ST_CRCH;
        end
      end
      mrs_pkg::ST_CRCH: begin
        if (slot_free) begin
          emit_go   = 1'b1;
          emit_b    = crc_r[15:8];
          emit_last = 1'b1;
          state_nxt = mrs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = mrs_pkg::ST_IDLE;
      end
    endcase

    if (emit_go) begin
      out_valid_nxt = 1'b1;
      out_kind_nxt  = mrs_pkg::RES_TX;
      out_byte_nxt  = emit_b;
      out_last_nxt  = emit_last;
      out_val_nxt   = 16'h0000;
      if (state_r != mrs_pkg::ST_CRCL) begin
        crc_nxt = mrs_pkg::crc_byte(crc_r, emit_b);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mrs_pkg::ST_IDLE;
      dev_r       <= 8'd1;
      rin_r       <= 5'd16;
      gap_r       <= 16'd2000;
      len_r       <= '0;
      idle_r      <= 16'h0000;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      idle_r      <= idle_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          mrs_pkg::CFG_DEV: dev_r <= cfg_wdata[7:0];
          mrs_pkg::CFG_RIN: rin_r <= cfg_wdata[4:0];
          mrs_pkg::CFG_GAP: gap_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  // payload and sequencer datapath
  always_ff @(posedge clk) begin
    eval_len_r <= eval_len_nxt;
    sc_r       <= sc_nxt;
    crc_r      <= crc_nxt;
    crc_lo_r   <= crc_lo_nxt;
    crc_hi_r   <= crc_hi_nxt;
    hdr_r      <= hdr_nxt;
    txb_r      <= txb_nxt;
    tx_n_r     <= tx_n_nxt;
    tk_r       <= tk_nxt;
    tx_rd_r    <= tx_rd_nxt;
    start_r    <= start_nxt;
    cnt_r      <= cnt_nxt;
    wi_r       <= wi_nxt;
    ph_r       <= ph_nxt;
    whi_r      <= whi_nxt;
    lrd_zero_r <= lrd_zero_nxt;
    out_kind_r <= out_kind_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
    out_val_r  <= out_val_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_result_kind = out_kind_r;
  assign out_tx_byte     = out_byte_r;
  assign out_tx_last     = out_last_r;
  assign out_read_value  = out_val_r;

  // a reply's last byte is never a local read result
  a_last_is_tx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_tx_last |-> out_result_kind == mrs_pkg::RES_TX)
    else $error("tx_last on a local read result");

  // a local read holds off the next item until its data is out
  a_lrd_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_kind == mrs_pkg::KIND_LRD |=> in_stall)
    else $error("input accepted during local read");

  // only frames of four or more bytes are scanned
  a_chk_len: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == mrs_pkg::ST_CHK |-> eval_len_r >= LEN_W'(4))
    else $error("short frame scanned");
endmodule
`default_nettype wire

// File: tb/modbus_rtu_register_slave_tb.sv
// testbench for the modbus rtu register slave: predicted replies checked item by item
`default_nettype none

module modbus_rtu_register_slave_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG = 20000;

  typedef struct packed {
    logic        rkind;
    logic [7:0]  txb;
    logic        last;
    logic [15:0] rval;
  } res_t;

  // scoreboard: keeps the predicted result items and compares the block's output
  class mrs_scoreboard;
    res_t pending[$];
    int   mismatches;
    int   matched;
    int   replies;

    // a prediction is noted when its input item is accepted
    function void note_input(res_t r);
      pending.push_back(r);
    endfunction

    function void check_result(res_t got);
      res_t exp_r;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result kind=%0d byte=%02h last=%0d value=%04h",
                   got.rkind, got.txb, got.last, got.rval);
        return;
      end
      exp_r = pending.pop_front();
      if (exp_r !== got) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch exp kind=%0d byte=%02h last=%0d value=%04h got %0d %02h %0d %04h",
                   exp_r.rkind, exp_r.txb, exp_r.last, exp_r.rval,
                   got.rkind, got.txb, got.last, got.rval);
      end else begin
        matched++;
        if (got.rkind == mrs_pkg::RES_TX && got.last) replies++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_kind;
  logic [7:0]  in_rx_byte;
  logic [3:0]  in_local_index;
  logic [15:0] in_local_value;
  logic        out_valid;
  logic        out_stall;
  logic        out_result_kind;
  logic [7:0]  out_tx_byte;
  logic        out_tx_last;
  logic [15:0] out_read_value;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_wdata;

  modbus_rtu_register_slave u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_kind(in_kind),
    .in_rx_byte(in_rx_byte), .in_local_index(in_local_index),
    .in_local_value(in_local_value),
    .out_valid(out_valid), .out_stall(out_stall), .out_result_kind(out_result_kind),
    .out_tx_byte(out_tx_byte), .out_tx_last(out_tx_last),
    .out_read_value(out_read_value),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  mrs_scoreboard board;

  // predictor state, mirrors the slave
  logic [7:0]  p_dev;
  logic [4:0]  p_rin;
  logic [15:0] p_gap;
  logic [7:0]  p_frame[64];
  int          p_len;
  logic [15:0] p_idle;
  logic [15:0] p_hold[16];

  // idling control: quiet stretch turns random idling off on both sides
  bit  quiet;
  int  idle_cycles;
  int  items_sent;
  bit  timed_out;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // sink side: random stalls, every accepted result goes to the scoreboard
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall)
        board.check_result({out_result_kind, out_tx_byte, out_tx_last, out_read_value});
      out_stall <= quiet ? 1'b0 : ($urandom_range(99) < 26);
    end
  end

  // watchdog: cycles with nothing accepted on either channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (rst_n && idle_cycles > WATCHDOG && !timed_out) begin
      timed_out = 1'b1;
      $display("watchdog expired, %0d predictions outstanding", board.pending.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic logic [15:0] crc16(input logic [7:0] msg[$]);
    logic [15:0] c;
    c = mrs_pkg::CRC_INIT;
    foreach (msg[i]) begin
      c = c ^ {8'h00, msg[i]};
      for (int b = 0; b < 8; b++) c = c[0] ? ((c >> 1) ^ mrs_pkg::CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic void emit_reply(input logic [7:0] msg[$]);
    logic [15:0] c;
    res_t r;
    c = crc16(msg);
    msg.push_back(c[7:0]);
    msg.push_back(c[15:8]);
    foreach (msg[i]) begin
      r = '{mrs_pkg::RES_TX, msg[i], (i == msg.size() - 1), 16'h0000};
      board.note_input(r);
    end
  endfunction

  function automatic void emit_exception(input logic [7:0] fn, input logic [7:0] code);
    logic [7:0] m[$];
    m = '{p_dev, fn | mrs_pkg::FN_EXC, code};
    emit_reply(m);
  endfunction

  // evaluates a closed frame, writes registers and queues the reply
  function automatic void evaluate_frame();
    logic [7:0] m[$];
    logic [7:0] fn;
    int lim, start, count, nbytes;
    lim = (p_rin > 16) ? 16 : p_rin;
    if (p_len < 4) return;
    if (p_frame[0] != p_dev) return;
    for (int i = 0; i < p_len - 2; i++) m.push_back(p_frame[i]);
    if ({p_frame[p_len-1], p_frame[p_len-2]} != crc16(m)) return;
    m.delete();
    fn = p_frame[1];
    start = {p_frame[2], p_frame[3]};
    if (fn == mrs_pkg::FN_READ) begin
      if (p_len < 6) return;
      count = {p_frame[4], p_frame[5]};
      if (start + count > lim) begin
        emit_exception(mrs_pkg::FN_READ, mrs_pkg::EXC_ADDR);
        return;
      end
      m = '{p_dev, mrs_pkg::FN_READ, 8'(count * 2)};
      for (int i = 0; i < count; i++) begin
        m.push_back(p_hold[start+i][15:8]);
        m.push_back(p_hold[start+i][7:0]);
      end
      emit_reply(m);
    end else if (fn == mrs_pkg::FN_WRITE1) begin
      if (p_len < 6) return;
      if (start >= lim) begin
        emit_exception(mrs_pkg::FN_WRITE1, mrs_pkg::EXC_ADDR);
        return;
      end
      p_hold[start] = {p_frame[4], p_frame[5]};
      for (int i = 0; i < 6; i++) m.push_back(p_frame[i]);
      emit_reply(m);
    end else if (fn == mrs_pkg::FN_WRITEN) begin
      if (p_len < 7) return;
      count = {p_frame[4], p_frame[5]};
      nbytes = p_frame[6];
      if (p_len < 7 + nbytes) return;
      if (nbytes < 2 * count) return;
      if (start + count > lim) begin
        emit_exception(mrs_pkg::FN_WRITEN, mrs_pkg::EXC_ADDR);
        return;
      end
      for (int i = 0; i < count; i++) p_hold[start+i] = {p_frame[7+2*i], p_frame[8+2*i]};
      m = '{p_dev, mrs_pkg::FN_WRITEN, 8'(start >> 8), 8'(start), 8'(count >> 8),
            8'(count)};
      emit_reply(m);
    end else begin
      emit_exception(fn, mrs_pkg::EXC_FUNC);
    end
  endfunction

  // predicts the results of one accepted input item
  function automatic void predict_item(input logic [1:0] k, input logic [7:0] b,
                                       input logic [3:0] idx, input logic [15:0] v);
    res_t r;
    case (k)
      mrs_pkg::KIND_BYTE: begin
        if (p_len < 64) begin
          p_frame[p_len] = b;
          p_len++;
        end
        p_idle = 16'h0000;
      end
      mrs_pkg::KIND_TICK: begin
        if (p_len != 0) begin
          if (p_idle != 16'hFFFF) p_idle++;
          if (p_idle > p_gap) begin
            evaluate_frame();
            p_len = 0;
            p_idle = 16'h0000;
          end
        end
      end
      mrs_pkg::KIND_LRD: begin
        r = '{mrs_pkg::RES_LRD, 8'h00, 1'b0, p_hold[idx]};
        board.note_input(r);
      end
      default: p_hold[idx] = v;
    endcase
  endfunction

  // drives one item and waits for its acceptance; valid drops only while idling
  task automatic send_item(input logic [1:0] k, input logic [7:0] b,
                           input logic [3:0] idx, input logic [15:0] v);
    while (!quiet && $urandom_range(99) < 26) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_kind        <= k;
    in_rx_byte     <= b;
    in_local_index <= idx;
    in_local_value <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_item(k, b, idx, v);
    items_sent++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_item(mrs_pkg::KIND_BYTE, b, 4'($urandom), 16'($urandom));
  endtask

  // enough ticks to close any frame under the current gap
  task automatic close_frame();
    for (int i = 0; i <= p_gap; i++)
      send_item(mrs_pkg::KIND_TICK, 8'($urandom), 4'($urandom), 16'($urandom));
  endtask

  // sends a message, its crc (optionally corrupted), then closes it
  task automatic send_frame(input logic [7:0] msg[$], input bit bad_crc);
    logic [15:0] c;
    c = crc16(msg) ^ (bad_crc ? 16'h0001 << $urandom_range(15) : 16'h0000);
    foreach (msg[i]) send_byte(msg[i]);
    send_byte(c[7:0]);
    send_byte(c[15:8]);
    close_frame();
  endtask

  // waits for all predictions, then a settle pause, before a config write
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [1:0] idx, input logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      mrs_pkg::CFG_DEV: p_dev = val[7:0];
      mrs_pkg::CFG_RIN: p_rin = val[4:0];
      default: p_gap = val;
    endcase
  endtask

  // a random frame, mostly well formed, with content aimed at live registers
  task automatic random_frame();
    logic [7:0] m[$];
    int sel, start, count;
    sel = $urandom_range(99);
    start = $urandom_range(17);
    count = $urandom_range(0, 5);
    m = '{($urandom_range(9) == 0) ? 8'($urandom) : p_dev};
    if (sel < 30) begin
      m.push_back(mrs_pkg::FN_READ);
      m.push_back(($urandom_range(19) == 0) ? 8'($urandom) : 8'h00);
      m.push_back(8'(start));
      m.push_back(8'h00);
      m.push_back(8'(count));
    end else if (sel < 55) begin
      m.push_back(mrs_pkg::FN_WRITE1);
      m.push_back(8'h00);
      m.push_back(8'(start));
      m.push_back(8'($urandom));
      m.push_back(8'($urandom));
    end else if (sel < 80) begin
      m.push_back(mrs_pkg::FN_WRITEN);
      m.push_back(8'h00);
      m.push_back(8'(start));
      m.push_back(8'h00);
      m.push_back(8'(count));
      m.push_back(8'(2 * count - (($urandom_range(7) == 0) ? 1 : 0)));
      for (int i = 0; i < 2 * count; i++) m.push_back(8'($urandom));
    end else if (sel < 90) begin
      m.push_back(8'($urandom));
      for (int i = 0; i < $urandom_range(4); i++) m.push_back(8'($urandom));
    end else begin
      for (int i = 0; i < $urandom_range(3); i++) m.push_back(8'($urandom));
    end
    send_frame(m, $urandom_range(11) == 0);
  endtask

  initial begin
    logic [7:0] m[$];
    board = new();
    quiet = 1'b0;
    timed_out = 1'b0;
    idle_cycles = 0;
    items_sent = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_kind = mrs_pkg::KIND_BYTE;
    in_rx_byte = 8'h00;
    in_local_index = 4'h0;
    in_local_value = 16'h0000;
    cfg_we = 1'b0;
    cfg_index = mrs_pkg::CFG_DEV;
    cfg_wdata = 16'h0000;
    p_dev = 8'h01;
    p_rin = 5'd16;
    p_gap = 16'd2000;
    p_len = 0;
    p_idle = 16'h0000;
    foreach (p_hold[i]) p_hold[i] = 16'h0000;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // short gap so frames close quickly
    write_cfg(mrs_pkg::CFG_GAP, 16'd1);

    // directed: tick on empty buffer, local extremes
    send_item(mrs_pkg::KIND_TICK, 8'hFF, 4'hF, 16'hFFFF);
    send_item(mrs_pkg::KIND_LWR, 8'h00, 4'h0, 16'hFFFF);
    send_item(mrs_pkg::KIND_LWR, 8'hFF, 4'hF, 16'hA55A);
    send_item(mrs_pkg::KIND_LRD, 8'h00, 4'h0, 16'h0000);
    send_item(mrs_pkg::KIND_LRD, 8'hFF, 4'hF, 16'hFFFF);
    // read all registers, then read of zero registers
    m = '{8'h01, mrs_pkg::FN_READ, 8'h00, 8'h00, 8'h00, 8'h10}; send_frame(m, 0);
    m = '{8'h01, mrs_pkg::FN_READ, 8'h00, 8'h05, 8'h00, 8'h00}; send_frame(m, 0);
    // write single, out of range write single, read out of range
    m = '{8'h01, mrs_pkg::FN_WRITE1, 8'h00, 8'h03, 8'hBE, 8'hEF}; send_frame(m, 0);
    m = '{8'h01, mrs_pkg::FN_WRITE1, 8'h00, 8'h10, 8'h12, 8'h34}; send_frame(m, 0);
    m = '{8'h01, mrs_pkg::FN_READ, 8'hFF, 8'hFF, 8'hFF, 8'hFF}; send_frame(m, 0);
    // write multiple, short data count, unknown function
    m = '{8'h01, mrs_pkg::FN_WRITEN, 8'h00, 8'h0E, 8'h00, 8'h02, 8'h04,
          8'h11, 8'h22, 8'h33, 8'h44}; send_frame(m, 0);
    m = '{8'h01, mrs_pkg::FN_WRITEN, 8'h00, 8'h00, 8'h00, 8'h02, 8'h03,
          8'h11, 8'h22, 8'h33}; send_frame(m, 0);
    m = '{8'h01, 8'h7F, 8'h00}; send_frame(m, 0);
    // wrong address, bad crc, runt frame
    m = '{8'h02, mrs_pkg::FN_READ, 8'h00, 8'h00, 8'h00, 8'h01}; send_frame(m, 0);
    m = '{8'h01, mrs_pkg::FN_READ, 8'h00, 8'h00, 8'h00, 8'h01}; send_frame(m, 1);
    m = '{8'h01}; send_frame(m, 0);
    // buffer overflow: 66 bytes sent, bytes past the 64th are discarded
    for (int i = 0; i < 66; i++) send_byte(8'($urandom));
    close_frame();
    drain();

    // random phases over several register settings
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin write_cfg(mrs_pkg::CFG_DEV, 16'h00FF); write_cfg(mrs_pkg::CFG_RIN, 16'd0); end
        1: begin write_cfg(mrs_pkg::CFG_DEV, 16'h0000); write_cfg(mrs_pkg::CFG_RIN, 16'd31); end
        2: begin write_cfg(mrs_pkg::CFG_DEV, 16'h005A); write_cfg(mrs_pkg::CFG_RIN, 16'd8);
                 write_cfg(mrs_pkg::CFG_GAP, 16'd3); end
        3: begin write_cfg(mrs_pkg::CFG_DEV, 16'h00A5); write_cfg(mrs_pkg::CFG_RIN, 16'd16);
                 write_cfg(mrs_pkg::CFG_GAP, 16'd1); quiet = 1'b1; end
        default: begin write_cfg(mrs_pkg::CFG_RIN, 16'd12); quiet = 1'b0; end
      endcase
      for (int n = 0; n < 2; n++) begin
        random_frame();
        if ($urandom_range(2) == 0)
          send_item(2'($urandom_range(2, 3)), 8'($urandom), 4'($urandom), 16'($urandom));
      end
      drain();
    end

    // a gap of 65535: the frame never closes, then a local read still answers
    write_cfg(mrs_pkg::CFG_GAP, 16'hFFFF);
    m = '{p_dev, mrs_pkg::FN_READ, 8'h00, 8'h00, 8'h00, 8'h01};
    foreach (m[i]) send_byte(m[i]);
    for (int i = 0; i < 6; i++) send_item(mrs_pkg::KIND_TICK, 8'h00, 4'h0, 16'h0000);
    send_item(mrs_pkg::KIND_LRD, 8'h00, 4'h7, 16'h0000);
    drain();

    $display("%0d input items sent, %0d results matched, %0d replies framed",
             items_sent, board.matched, board.replies);
    $display("covered read, write single, write multiple, exceptions and dropped frames");
    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", board.mismatches);
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

`default_nettype wire
